>>> sv/mfir_pkg.sv
// Package with shared widths, codes, state type and control structs of the FIR filter.
`timescale 1ns / 1ps

package mfir_pkg;

    localparam int CMD_W    = 2;
    localparam int CH_W     = 3;
    localparam int CIDX_W   = 5;
    localparam int CFG_W    = 6;
    localparam int OUT_BITS = 37;
    localparam int TAP_RESET = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILTER = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_HEAD,
        ST_DRAIN,
        ST_MAC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic rd_issue;
        logic head_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_filter;
        logic taps_short;
        logic cnt_zero;
        logic out_free;
    } t_status;

endpackage

>>> sv/mfir_ctrl.sv
// Controller state machine that sequences one filter transaction.
`timescale 1ns / 1ps

module mfir_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mfir_pkg::t_status i_status,
    output mfir_pkg::t_cmd    o_cmd
);

    mfir_pkg::t_state r_state;
    mfir_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfir_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mfir_pkg::ST_IDLE: begin
                if (i_valid && i_status.is_filter) begin
                    n_state = i_status.taps_short ? mfir_pkg::ST_HEAD : mfir_pkg::ST_READ;
                end
            end
            mfir_pkg::ST_READ: begin
                if (i_status.cnt_zero) begin
                    n_state = mfir_pkg::ST_HEAD;
                end
            end
            mfir_pkg::ST_HEAD:  n_state = mfir_pkg::ST_DRAIN;
            mfir_pkg::ST_DRAIN: n_state = mfir_pkg::ST_MAC;
            mfir_pkg::ST_MAC:   n_state = mfir_pkg::ST_OUT;
            mfir_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = mfir_pkg::ST_IDLE;
                end
            end
            default: n_state = mfir_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            mfir_pkg::ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
                o_cmd.start  = i_valid && i_status.is_filter;
            end
            mfir_pkg::ST_READ:  o_cmd.rd_issue   = 1'b1;
            mfir_pkg::ST_HEAD:  o_cmd.head_issue = 1'b1;
            mfir_pkg::ST_DRAIN: o_cmd = '0;
            mfir_pkg::ST_MAC:   o_cmd = '0;
            mfir_pkg::ST_OUT:   o_cmd.out_load = i_status.out_free;
            default:            o_cmd = '0;
        endcase
    end

endmodule

>>> sv/mfir_datapath.sv
// Datapath with history memory, coefficient table, multiplier, accumulator and output register.
`timescale 1ns / 1ps

module mfir_datapath #(
    parameter int MAX_TAPS    = 32,
    parameter int CHANNELS    = 7,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mfir_pkg::t_cmd                    i_cmd,
    output mfir_pkg::t_status                 o_status,
    input  logic                              i_cfg_wr_en,
    input  logic [mfir_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  logic [mfir_pkg::CMD_W-1:0]        i_command,
    input  logic [mfir_pkg::CH_W-1:0]         i_channel,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic [mfir_pkg::CIDX_W-1:0]       i_coef_index,
    input  logic signed [COEF_BITS-1:0]       i_coef_value,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [mfir_pkg::CH_W-1:0]         o_out_channel,
    output logic signed [mfir_pkg::OUT_BITS-1:0] o_filtered
);

    localparam int Depth  = CHANNELS * MAX_TAPS;
    localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int TapW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CntW   = $clog2(MAX_TAPS + 1);
    localparam int ProdW  = SAMPLE_BITS + COEF_BITS;
    localparam int OutW   = mfir_pkg::OUT_BITS;
    localparam int TapsRst = (mfir_pkg::TAP_RESET > MAX_TAPS) ? MAX_TAPS : mfir_pkg::TAP_RESET;

    logic signed [SAMPLE_BITS-1:0] r_mem [Depth];
    logic [Depth-1:0]              r_hvalid;
    logic signed [COEF_BITS-1:0]   r_coef_tab [MAX_TAPS];

    logic [CntW-1:0]               r_taps;
    logic [TapW-1:0]               r_cnt;
    logic [AddrW-1:0]              r_base;
    logic [mfir_pkg::CH_W-1:0]     r_ch;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    logic                          r_op_v;
    logic                          r_op_mem;
    logic                          r_op_mac;
    logic signed [COEF_BITS-1:0]   r_coef;
    logic [AddrW-1:0]              r_wr_addr;
    logic signed [SAMPLE_BITS-1:0] r_mem_q;
    logic                          r_mem_ok;

    logic signed [ProdW-1:0]       r_prod;
    logic                          r_prod_v;
    logic signed [OutW-1:0]        r_acc;

    logic                          r_out_valid;
    logic [mfir_pkg::CH_W-1:0]     r_out_ch;
    logic signed [OutW-1:0]        r_out_filt;

    logic                          item_ch_ok;
    logic [AddrW-1:0]              in_base;
    logic [AddrW-1:0]              rd_addr;
    logic [TapW-1:0]               rd_tap;
    logic signed [SAMPLE_BITS-1:0] op_data;
    logic signed [ProdW-1:0]       n_prod;

    assign item_ch_ok = int'(i_channel) < CHANNELS;
    assign in_base    = AddrW'(int'(i_channel) * MAX_TAPS);
    assign rd_addr    = AddrW'(r_base + AddrW'(r_cnt));
    assign rd_tap     = TapW'(r_cnt + TapW'(1));
    assign op_data    = r_op_mem ? (r_mem_ok ? r_mem_q : '0) : r_sample;
    assign n_prod     = op_data * r_coef;

    assign o_status.is_filter  = (i_command == mfir_pkg::CMD_FILTER) && item_ch_ok;
    assign o_status.taps_short = r_taps <= CntW'(1);
    assign o_status.cnt_zero   = r_cnt == '0;
    assign o_status.out_free   = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (r_op_v) begin
            r_mem[r_wr_addr] <= op_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
            r_mem_ok <= 1'b0;
        end else begin
            r_mem_ok <= r_hvalid[rd_addr];
            if (i_cmd.accept && i_command == mfir_pkg::CMD_CLEAR) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    for (int t = 0; t < MAX_TAPS; t++) begin
                        if (int'(i_channel) == c) begin
                            r_hvalid[c * MAX_TAPS + t] <= 1'b0;
                        end
                    end
                end
            end
            if (r_op_v) begin
                r_hvalid[r_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < MAX_TAPS; t++) begin
                r_coef_tab[t] <= '0;
            end
        end else if (i_cmd.accept && i_command == mfir_pkg::CMD_COEF
                     && int'(i_coef_index) < MAX_TAPS) begin
            r_coef_tab[TapW'(i_coef_index)] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= CntW'(TapsRst);
        end else if (i_cfg_wr_en) begin
            if (int'(i_cfg_wr_data) > MAX_TAPS) begin
                r_taps <= CntW'(MAX_TAPS);
            end else begin
                r_taps <= CntW'(i_cfg_wr_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cnt    <= TapW'(r_taps - CntW'(2));
            r_base   <= in_base;
            r_ch     <= i_channel;
            r_sample <= i_sample;
        end else if (i_cmd.rd_issue) begin
            r_cnt <= r_cnt - TapW'(1);
        end
        if (i_cmd.head_issue) begin
            r_coef    <= r_coef_tab[0];
            r_wr_addr <= r_base;
        end else begin
            r_coef    <= r_coef_tab[rd_tap];
            r_wr_addr <= AddrW'(rd_addr + AddrW'(1));
        end
        r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_v   <= 1'b0;
            r_op_mem <= 1'b0;
            r_op_mac <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_op_v   <= i_cmd.rd_issue || i_cmd.head_issue;
            r_op_mem <= i_cmd.rd_issue;
            r_op_mac <= i_cmd.rd_issue || (r_taps != '0);
            r_prod_v <= r_op_v && r_op_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + OutW'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ch   <= r_ch;
            r_out_filt <= r_acc;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_filtered    = r_out_filt;

endmodule

>>> sv/multichannel_fir_filter.sv
// Top level of the seven-channel FIR filter with shared coefficient table.
//
//  Channel  Handshake            Payload
//  input    i_valid / o_stall    i_command, i_channel, i_sample, i_coef_index, i_coef_value
//  output   o_valid / i_stall    o_out_channel, o_filtered
//  config   i_cfg_wr_en          i_cfg_wr_data (tap count)
//
// A filter transaction steps through ST_READ (for a tap count of two or more), ST_HEAD,
// ST_DRAIN, ST_MAC and ST_OUT; one history memory port and one multiplier set this sequence.
// Coefficient writes and history clears do not stall the input. Reset is synchronous and clears
// control state, the coefficient table and the per-entry history valid bits at once.
// A finished result waits in the output register while the next transaction is taken;
// a later filter result holds the block until that register is free.
`timescale 1ns / 1ps

module multichannel_fir_filter #(
    parameter int MAX_TAPS    = 32,
    parameter int CHANNELS    = 7,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mfir_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mfir_pkg::CMD_W-1:0]        i_command,
    input  logic [mfir_pkg::CH_W-1:0]         i_channel,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic [mfir_pkg::CIDX_W-1:0]       i_coef_index,
    input  logic signed [COEF_BITS-1:0]       i_coef_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [mfir_pkg::CH_W-1:0]         o_out_channel,
    output logic signed [mfir_pkg::OUT_BITS-1:0] o_filtered
);

    mfir_pkg::t_cmd    cmd;
    mfir_pkg::t_status status;

    mfir_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mfir_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .i_coef_index  (i_coef_index),
        .i_coef_value  (i_coef_value),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_channel (o_out_channel),
        .o_filtered    (o_filtered)
    );

endmodule

>>> sv/mfir_checker.sv
// Port-level checker for the FIR filter and the bind that attaches it.
`timescale 1ns / 1ps

module mfir_checker #(
    parameter int CHANNELS = 7
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic [mfir_pkg::CMD_W-1:0]        i_command,
    input logic [mfir_pkg::CH_W-1:0]         i_channel,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [mfir_pkg::CH_W-1:0]         o_out_channel,
    input logic [mfir_pkg::OUT_BITS-1:0]     o_filtered
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid is set right after reset.");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered) && $stable(o_out_channel))
        else $error("Stalled output transaction changed.");

    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_command == mfir_pkg::CMD_FILTER
        && int'(i_channel) < CHANNELS |=> o_stall)
        else $error("Filter transaction did not occupy the block.");

    a_short_items_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_command != mfir_pkg::CMD_FILTER |=> !o_stall)
        else $error("Write or clear transaction stalled the input.");

    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("Result appeared without a filter run.");

endmodule

bind multichannel_fir_filter mfir_checker #(.CHANNELS(CHANNELS)) u_checker (.*);
